// File: sv/two_channel_sliding_median_filter_macros.svh
// ----------------------------------------------------------------------------
// Two-channel sliding median filter: assertion macros
// Shared property forms for the port checker of the filter.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_SLIDING_MEDIAN_FILTER_MACROS_SVH
`define TWO_CHANNEL_SLIDING_MEDIAN_FILTER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TCSMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCSMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/tcsmf_pkg.sv
// ----------------------------------------------------------------------------
// Two-channel sliding median filter: package
// Types and fixed constants shared by the filter modules.
// ----------------------------------------------------------------------------
package tcsmf_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CHAN_W = 2;
	localparam int unsigned CMD_W = 8;
	localparam logic [CMD_W-1:0] CMD_BASE = 8'h84;
	localparam int unsigned CMD_CH_SHIFT = 6;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic run;
	} cell_ctl_t;

endpackage

// File: sv/tcsmf_cell.sv
// ----------------------------------------------------------------------------
// Two-channel sliding median filter: window cell
// Holds one window position for every channel and ranks its own sample
// against the samples that pass by on the ring.
// ----------------------------------------------------------------------------
module tcsmf_cell #(
	parameter int unsigned WINDOW_SIZE = 5,
	parameter int unsigned NUM_CHANNELS = 2,
	parameter int unsigned CELL_IDX = 0,
	localparam int unsigned IDX_W = $clog2(WINDOW_SIZE),
	localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcsmf_pkg::cell_ctl_t ctl,
	input  logic                 wr_en,
	input  logic [CH_W-1:0]      ch_sel,
	input  tcsmf_pkg::sample_t   sample,
	input  tcsmf_pkg::sample_t   ring_in,
	input  logic [IDX_W-1:0]     ring_idx_in,
	output tcsmf_pkg::sample_t   ring_out,
	output logic [IDX_W-1:0]     ring_idx_out,
	output tcsmf_pkg::sample_t   value_out,
	output logic [IDX_W-1:0]     rank_out
);

	tcsmf_pkg::sample_t win_q [NUM_CHANNELS];
	tcsmf_pkg::sample_t ring_q;
	logic [IDX_W-1:0]   ring_idx_q;
	logic [IDX_W-1:0]   rank_q;
	tcsmf_pkg::sample_t own;
	logic               below;

	assign own = win_q[ch_sel];
	assign below = (ring_q < own) || ((ring_q == own) && (ring_idx_q < IDX_W'(CELL_IDX)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				win_q[i] <= '0;
			end
		end else if (wr_en) begin
			win_q[ch_sel] <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ring_q <= own;
			ring_idx_q <= IDX_W'(CELL_IDX);
			rank_q <= '0;
		end else if (ctl.run) begin
			ring_q <= ring_in;
			ring_idx_q <= ring_idx_in;
			if (below) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	assign ring_out = ring_q;
	assign ring_idx_out = ring_idx_q;
	assign value_out = own;
	assign rank_out = rank_q;

endmodule

// File: sv/two_channel_sliding_median_filter.sv
// ----------------------------------------------------------------------------
// Two-channel sliding median filter: top level
// Keeps a circular sample window per channel in a row of cells and returns
// the window median, the previous median and the converter command byte.
//
// Chan Handshake            Fields
// in   in_valid/in_stall    channel, sample
// out  out_valid/out_stall  channel_out, bad_channel, adc_command, filtered_value, previous_value
//
// An in-range request passes through a load step, WINDOW_SIZE ring shifts that rank
// every cell's sample, and a step that registers the result; the next request is
// accepted after that.
// A request with a bad channel goes from idle straight to the done state, which
// registers its result; the next request is accepted after that, and it changes no window, write position or median.
// Reset clears all windows, write positions and medians at once.
// A stalled result holds in the output register while the next request is
// accepted; the block then waits before overwriting it.
// ----------------------------------------------------------------------------
module two_channel_sliding_median_filter #(
	parameter int unsigned WINDOW_SIZE = 5,
	parameter int unsigned NUM_CHANNELS = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            channel,
	input  logic signed [15:0]    sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            channel_out,
	output logic                  bad_channel,
	output logic [7:0]            adc_command,
	output logic signed [15:0]    filtered_value,
	output logic signed [15:0]    previous_value
);

	localparam int unsigned IDX_W = $clog2(WINDOW_SIZE);
	localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IDX_W-1:0] MID = IDX_W'(WINDOW_SIZE / 2);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_SIZE - 1);

	tcsmf_pkg::state_t    state_q, state_d;
	tcsmf_pkg::cell_ctl_t ctl;
	logic [tcsmf_pkg::CHAN_W-1:0] ch_q;
	logic                 bad_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     wpos_q [NUM_CHANNELS];
	tcsmf_pkg::sample_t   med_q [NUM_CHANNELS];

	logic                 accept;
	logic                 in_range;
	logic                 finish;
	logic [CH_W-1:0]      ch_sel;
	logic [CH_W-1:0]      in_ch;

	logic [WINDOW_SIZE-1:0] wr_en;
	tcsmf_pkg::sample_t   ring_v [WINDOW_SIZE];
	logic [IDX_W-1:0]     ring_idx [WINDOW_SIZE];
	tcsmf_pkg::sample_t   cell_v [WINDOW_SIZE];
	logic [IDX_W-1:0]     rank [WINDOW_SIZE];
	tcsmf_pkg::sample_t   median;

	logic                 out_valid_q;
	logic [1:0]           channel_out_q;
	logic                 bad_channel_q;
	logic [7:0]           adc_command_q;
	tcsmf_pkg::sample_t   filtered_value_q;
	tcsmf_pkg::sample_t   previous_value_q;

	assign in_ch = channel[CH_W-1:0];
	assign in_range = {1'b0, channel} < 3'(NUM_CHANNELS);
	assign accept = in_valid && !in_stall;
	assign ch_sel = (state_q == tcsmf_pkg::ST_IDLE) ? in_ch : ch_q[CH_W-1:0];

	always_comb begin
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			wr_en[i] = accept && in_range && (wpos_q[in_ch] == IDX_W'(i));
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcsmf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = in_range ? tcsmf_pkg::ST_LOAD : tcsmf_pkg::ST_DONE;
				end
			end
			tcsmf_pkg::ST_LOAD: begin
				state_d = tcsmf_pkg::ST_RUN;
			end
			tcsmf_pkg::ST_RUN: begin
				if (cnt_q == LAST) begin
					state_d = tcsmf_pkg::ST_DONE;
				end
			end
			tcsmf_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = tcsmf_pkg::ST_IDLE;
				end
			end
			default: state_d = tcsmf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		ctl = '0;
		finish = 1'b0;
		unique case (state_q)
			tcsmf_pkg::ST_IDLE: in_stall = 1'b0;
			tcsmf_pkg::ST_LOAD: ctl.load = 1'b1;
			tcsmf_pkg::ST_RUN:  ctl.run = 1'b1;
			tcsmf_pkg::ST_DONE: finish = !out_valid_q || !out_stall;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcsmf_pkg::ST_IDLE;
			ch_q <= '0;
			bad_q <= 1'b0;
			cnt_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				wpos_q[i] <= '0;
				med_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				ch_q <= channel;
				bad_q <= !in_range;
				if (in_range) begin
					wpos_q[in_ch] <= (wpos_q[in_ch] == LAST) ? '0 : wpos_q[in_ch] + 1'b1;
				end
			end
			if (ctl.load) begin
				cnt_q <= '0;
			end else if (ctl.run) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish && !bad_q) begin
				med_q[ch_q[CH_W-1:0]] <= median;
			end
		end
	end

	for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
		localparam int unsigned PREV = (g == 0) ? WINDOW_SIZE - 1 : g - 1;
		tcsmf_cell #(
			.WINDOW_SIZE  (WINDOW_SIZE),
			.NUM_CHANNELS (NUM_CHANNELS),
			.CELL_IDX     (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.wr_en        (wr_en[g]),
			.ch_sel       (ch_sel),
			.sample       (sample),
			.ring_in      (ring_v[PREV]),
			.ring_idx_in  (ring_idx[PREV]),
			.ring_out     (ring_v[g]),
			.ring_idx_out (ring_idx[g]),
			.value_out    (cell_v[g]),
			.rank_out     (rank[g])
		);
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			if (rank[i] == MID) begin
				median = median | cell_v[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			channel_out_q <= ch_q;
			bad_channel_q <= bad_q;
			if (bad_q) begin
				adc_command_q <= '0;
				filtered_value_q <= '0;
				previous_value_q <= '0;
			end else begin
				adc_command_q <= tcsmf_pkg::CMD_BASE
					| (8'(ch_q) << tcsmf_pkg::CMD_CH_SHIFT);
				filtered_value_q <= median;
				previous_value_q <= med_q[ch_q[CH_W-1:0]];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign channel_out = channel_out_q;
	assign bad_channel = bad_channel_q;
	assign adc_command = adc_command_q;
	assign filtered_value = filtered_value_q;
	assign previous_value = previous_value_q;

endmodule

// File: sv/tcsmf_chk.sv
// ----------------------------------------------------------------------------
// Two-channel sliding median filter: port checker
// Watches the filter's ports and flags results that break its contract.
// ----------------------------------------------------------------------------
`include "two_channel_sliding_median_filter_macros.svh"

module tcsmf_chk #(
	parameter int unsigned NUM_CHANNELS = 2
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         channel_out,
	input logic               bad_channel,
	input logic [7:0]         adc_command,
	input logic signed [15:0] filtered_value,
	input logic signed [15:0] previous_value
);

	logic        out_held;
	logic [42:0] out_bus;
	logic        bad_expected;
	logic [7:0]  cmd_expected;
	logic        zero_data;

	assign out_held = out_valid && out_stall;
	assign out_bus = {channel_out, bad_channel, adc_command, filtered_value, previous_value};
	assign bad_expected = {1'b0, channel_out} >= 3'(NUM_CHANNELS);
	assign cmd_expected = tcsmf_pkg::CMD_BASE | {channel_out, 6'b000000};
	assign zero_data = (adc_command == 8'h00) && (filtered_value == 16'sd0)
		&& (previous_value == 16'sd0);

	`TCSMF_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_bus), "Stalled result moved.")
	`TCSMF_ASSERT_NOW(a_bad_flag, out_valid, bad_channel == bad_expected, "Bad channel flag wrong.")
	`TCSMF_ASSERT_NOW(a_bad_zero, out_valid && bad_channel, zero_data, "Rejected request has data.")
	`TCSMF_ASSERT_NOW(a_cmd, out_valid && !bad_channel, adc_command == cmd_expected, "Bad command.")
	`TCSMF_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "Request accepted while busy.")

endmodule

bind two_channel_sliding_median_filter tcsmf_chk #(.NUM_CHANNELS(NUM_CHANNELS)) u_tcsmf_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.channel_out    (channel_out),
	.bad_channel    (bad_channel),
	.adc_command    (adc_command),
	.filtered_value (filtered_value),
	.previous_value (previous_value)
);
